@@ rtl/core/sliding_window_max_top_defines.svh @@
// ----------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MAX_TOP_DEFINES_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum: package
// Payload types, the candidate entry type and the max-select helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int CFG_BITS           = 7;
    localparam int DEFAULT_MAX_WINDOW = 64;
    localparam int WINDOW_RESET       = 3;

    typedef logic signed [SAMPLE_BITS-1:0] swm_sample_t;

    typedef struct packed {
        swm_sample_t sample;
        logic        last_sample;
    } swm_in_t;

    typedef struct packed {
        swm_sample_t window_max;
        logic        end_of_sequence;
    } swm_out_t;

    typedef struct packed {
        logic        valid;
        swm_sample_t value;
    } swm_entry_t;

    typedef struct packed {
        logic valid;
        logic last;
    } swm_tag_t;

    // on a tie the first argument wins
    function automatic swm_entry_t swm_pick(input swm_entry_t a, input swm_entry_t b);
        swm_entry_t r;
        if (!a.valid)
            r = b;
        else if (!b.valid)
            r = a;
        else if (b.value > a.value)
            r = b;
        else
            r = a;
        return r;
    endfunction

    function automatic int swm_ceil_log4(input int n);
        int levels;
        int span;
        levels = 0;
        span   = 1;
        for (int i = 0; i < 8; i++)
        begin
            if (span < n)
            begin
                span   = span * 4;
                levels = levels + 1;
            end
        end
        return levels;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/swm_cell.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum: candidate cell
// Holds one past sample; shifts one place per beat and drops out of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell #(
    parameter int WIN_W = 7,
    parameter int POS   = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift,
    input  logic                      clear,
    input  logic [WIN_W-1:0]          win,
    input  swm_pkg::swm_entry_t       prev,
    output swm_pkg::swm_entry_t       cur
);
    import swm_pkg::*;

    localparam logic [WIN_W-1:0] POS_V = WIN_W'(POS);

    logic        valid_reg;
    swm_sample_t value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (shift)
            valid_reg <= prev.valid && !clear;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
            value_reg <= prev.value;
    end

    // age of this cell's sample is POS; it is live while age < window
    assign cur.valid = valid_reg && (POS_V < win);
    assign cur.value = value_reg;

endmodule

`default_nettype wire

@@ rtl/core/swm_stage.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum: reduction stage
// Registered 4:1 max over candidate entries, with its own beat handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_stage #(
    parameter int N_OUT = 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swm_pkg::swm_tag_t                     in_tag,
    input  swm_pkg::swm_entry_t [4*N_OUT-1:0]     in_ent,
    output logic                                  in_ready,
    output swm_pkg::swm_tag_t                     out_tag,
    output swm_pkg::swm_entry_t [N_OUT-1:0]       out_ent,
    input  logic                                  out_ready
);
    import swm_pkg::*;

    swm_tag_t                tag_reg;
    swm_entry_t [N_OUT-1:0]  ent_reg;
    swm_entry_t [N_OUT-1:0]  ent_next;

    assign in_ready = !tag_reg.valid || out_ready;

    always_comb
    begin
        for (int g = 0; g < N_OUT; g++)
            ent_next[g] = swm_pick(swm_pick(in_ent[4*g],   in_ent[4*g+1]),
                                   swm_pick(in_ent[4*g+2], in_ent[4*g+3]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else if (in_ready)
            tag_reg <= in_tag;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_tag.valid)
            ent_reg <= ent_next;
    end

    assign out_tag = tag_reg;
    assign out_ent = ent_reg;

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_max_top.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum: top level
// Running maximum of the last window_size signed samples of a sequence.
// ----------------------------------------------------------------------------
//  channel   signals                       beat taken when
//  input     in_valid, in_stall, in_data   in_valid && !in_stall
//  output    out_valid, out_stall, out_data out_valid && !out_stall
//  config    cfg_we, cfg_wdata             cfg_we
//
//  One sample per cycle while in_stall is low; each result passes through
//  the registered 4:1 max tree before it leaves.
//  The cell chain updates in the accept cycle, so the tree is the only latency.
//  Reset empties the cells, clears the sample count and sets the window to 3.
//  out_stall backs up through the tree stages to in_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_max_top_defines.svh"

module sliding_window_max_top #(
    parameter int MAX_WINDOW = swm_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  swm_pkg::swm_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output swm_pkg::swm_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wdata
);
    import swm_pkg::*;

    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W     = (WIN_W > CFG_BITS) ? WIN_W : CFG_BITS;
    localparam int NUM_CELLS = MAX_WINDOW - 1;
    localparam int LEVELS    = swm_ceil_log4(MAX_WINDOW);
    localparam int LEAVES    = 1 << (2 * LEVELS);

    logic [CFG_BITS-1:0]  window_size_reg;
    logic [WIN_W-1:0]     seen_reg;
    logic [WIN_W-1:0]     seen_next;
    logic [WIN_W-1:0]     seen_inc;
    logic [WIN_W-1:0]     win_eff;
    logic [CMP_W-1:0]     ws_ext;
    logic                 produce;
    logic                 accept;
    logic                 clear;
    swm_tag_t             head_tag;

    swm_entry_t [NUM_CELLS-1:0]  cell_prev;
    swm_entry_t [NUM_CELLS-1:0]  cell_cur;
    logic       [NUM_CELLS-1:0]  live_bits;
    swm_entry_t [LEAVES-1:0]     leaf_ent;

    wire swm_entry_t [LEVELS:0][LEAVES-1:0] lvl_ent;
    wire swm_tag_t   [LEVELS:0]             lvl_tag;
    wire             [LEVELS:0]             lvl_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= CFG_BITS'(WINDOW_RESET);
        else if (cfg_we)
            window_size_reg <= cfg_wdata;
    end

    always_comb
    begin
        ws_ext = CMP_W'(window_size_reg);
        if (ws_ext == '0)
            win_eff = WIN_W'(1);
        else if (ws_ext > CMP_W'(MAX_WINDOW))
            win_eff = WIN_W'(MAX_WINDOW);
        else
            win_eff = WIN_W'(ws_ext);
    end

    assign seen_inc  = (seen_reg == WIN_W'(MAX_WINDOW)) ? seen_reg : seen_reg + WIN_W'(1);
    assign produce   = (seen_inc >= win_eff) || in_data.last_sample;
    assign accept    = in_valid && lvl_ready[0];
    assign clear     = accept && in_data.last_sample;
    assign in_stall  = !lvl_ready[0];
    assign seen_next = clear ? '0 : seen_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (accept)
            seen_reg <= seen_next;
    end

    // cell chain: newest sample enters cell 0, each beat moves one place
    always_comb
    begin
        cell_prev[0].valid = 1'b1;
        cell_prev[0].value = in_data.sample;
        for (int j = 1; j < NUM_CELLS; j++)
            cell_prev[j] = cell_cur[j-1];
        for (int j = 0; j < NUM_CELLS; j++)
            live_bits[j] = cell_cur[j].valid;
    end

    genvar c;
    generate
        for (c = 0; c < NUM_CELLS; c++)
        begin : gen_cell
            swm_cell #(
                .WIN_W (WIN_W),
                .POS   (c + 1)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (accept),
                .clear (clear),
                .win   (win_eff),
                .prev  (cell_prev[c]),
                .cur   (cell_cur[c])
            );
        end
    endgenerate

    // leaves: live candidates plus the incoming sample
    always_comb
    begin
        leaf_ent = '0;
        for (int j = 0; j < NUM_CELLS; j++)
            leaf_ent[j] = cell_cur[j];
        leaf_ent[MAX_WINDOW-1].valid = 1'b1;
        leaf_ent[MAX_WINDOW-1].value = in_data.sample;
    end

    assign head_tag.valid = accept && produce;
    assign head_tag.last  = in_data.last_sample;

    assign lvl_ent[0]        = leaf_ent;
    assign lvl_tag[0]        = head_tag;
    assign lvl_ready[LEVELS] = !out_stall;

    genvar k;
    generate
        for (k = 0; k < LEVELS; k++)
        begin : gen_lvl
            localparam int N_OUT = LEAVES >> (2 * (k + 1));

            swm_stage #(
                .N_OUT (N_OUT)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_tag    (lvl_tag[k]),
                .in_ent    (lvl_ent[k][4*N_OUT-1:0]),
                .in_ready  (lvl_ready[k]),
                .out_tag   (lvl_tag[k+1]),
                .out_ent   (lvl_ent[k+1][N_OUT-1:0]),
                .out_ready (lvl_ready[k+1])
            );

            assign lvl_ent[k+1][LEAVES-1:N_OUT] = '0;
        end
    endgenerate

    assign out_valid                = lvl_tag[LEVELS].valid;
    assign out_data.window_max      = lvl_ent[LEVELS][0].value;
    assign out_data.end_of_sequence = lvl_tag[LEVELS].last;

    `SWM_ASSERT_NEXT(a_last_clears_count, clear, seen_reg == '0, "count not cleared by last beat")
    `SWM_ASSERT_NEXT(a_last_empties_cells, clear, live_bits == '0, "cells live after last beat")
    `SWM_ASSERT_NOW(a_result_has_entry, out_valid, lvl_ent[LEVELS][0].valid, "result without entry")

endmodule

`default_nettype wire
